FILE: hdl/cia_pkg.sv
package cia_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned UNIT_W = DATA_W + 1;
   localparam int unsigned RES_W  = 2 * DATA_W;
   localparam int unsigned CNT_W  = $clog2(DATA_W);

   // Largest magnitudes that stay strictly inside the signed range
   localparam logic [DATA_W-1:0] POS_MAG_MAX = 32'h7FFF_FFFE;
   localparam logic [DATA_W-1:0] NEG_MAG_MAX = 32'h7FFF_FFFF;
   // Any base of magnitude two or more overflows beyond this exponent
   localparam logic [DATA_W-1:0] POW_EXP_MAX = 32'd30;

   typedef enum logic [2:0] {
      KIND_ADD = 3'd0,
      KIND_SUB = 3'd1,
      KIND_MUL = 3'd2,
      KIND_DIV = 3'd3,
      KIND_POW = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_NOT_INTEGRAL = 2'd1,
      ST_DIV_ZERO     = 2'd2,
      ST_OVERFLOW     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      UNIT_ADD,
      UNIT_SUB,
      UNIT_MUL
   } unit_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_DIV,
      S_POW,
      S_FINAL
   } state_type;

   typedef struct packed {
      unit_op_type       op;
      logic [UNIT_W-1:0] x;
      logic [UNIT_W-1:0] y;
   } unit_req_type;

endpackage

FILE: hdl/cia_unit.sv
module cia_unit import cia_pkg::*; (
   input  unit_req_type      req,
   output logic [RES_W-1:0]  res
);

   logic [RES_W-1:0] x_ext;
   logic [RES_W-1:0] y_ext;
   logic [RES_W-1:0] prod;

   // add and subtract work on sign-extended operands
   assign x_ext = {{(RES_W-UNIT_W){req.x[UNIT_W-1]}}, req.x};
   assign y_ext = {{(RES_W-UNIT_W){req.y[UNIT_W-1]}}, req.y};
   // 32 by 32 unsigned multiply, zero-extended so the full product is kept
   assign prod  = RES_W'(req.x[DATA_W-1:0]) * RES_W'(req.y[DATA_W-1:0]);

   always_comb begin
      case (req.op)
         UNIT_ADD: res = x_ext + y_ext;
         UNIT_SUB: res = x_ext - y_ext;
         UNIT_MUL: res = prod;
         default:  res = '0;
      endcase
   end

endmodule

FILE: hdl/checked_int_alu.sv
// An accepted start goes through setup and then the final state, which registers
// rsp_valid; divide adds a loop between them (one quotient bit a cycle) and power a
// multiply loop (one multiply a cycle, at most 30 of them).
// One item at a time: busy stays high until the result is out; a new start may be
// taken in the cycle rsp_valid is high. The result is a one-cycle strobe.
// Synchronous active-high reset returns the sequencer to idle and drops rsp_valid.
module checked_int_alu import cia_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [2:0]        req_kind,
   input  logic [DATA_W-1:0] req_operand_a,
   input  logic [DATA_W-1:0] req_operand_b,
   output logic              rsp_valid,
   output logic [DATA_W-1:0] rsp_value,
   output logic [1:0]        rsp_status
);

   state_type         state_ff, state_in;
   logic [2:0]        kind_ff, kind_in;
   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic [DATA_W-1:0] magb_ff, magb_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic              big_ff, big_in;
   status_type        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type        rsp_status_ff, rsp_status_in;

   unit_req_type      unit_req;
   logic [RES_W-1:0]  unit_res;

   logic              sign_a, sign_b;
   logic [DATA_W-1:0] mag_a, mag_b;
   logic [UNIT_W:0]   sum_lo, sum_mag;
   logic              fits;
   logic [DATA_W-1:0] rem_next;
   logic              res_ok;

   cia_unit u_unit (
      .req (unit_req),
      .res (unit_res)
   );

   assign sign_a  = a_ff[DATA_W-1];
   assign sign_b  = b_ff[DATA_W-1];
   assign mag_a   = sign_a ? (~a_ff + 1'b1) : a_ff;
   assign mag_b   = sign_b ? (~b_ff + 1'b1) : b_ff;
   assign sum_lo  = unit_res[UNIT_W:0];
   assign sum_mag = sum_lo[UNIT_W] ? (~sum_lo + 1'b1) : sum_lo;

   // restoring division step: trial subtract of the divisor
   assign fits     = !unit_res[RES_W-1];
   assign rem_next = fits ? unit_res[DATA_W-1:0] : {rem_ff[DATA_W-2:0], acc_ff[DATA_W-1]};

   assign res_ok = (status_ff == ST_OK) && !big_ff &&
                   (neg_ff ? (acc_ff <= NEG_MAG_MAX) : (acc_ff <= POS_MAG_MAX));

   always_comb begin
      unit_req.op = UNIT_ADD;
      unit_req.x  = '0;
      unit_req.y  = '0;
      case (state_ff)
         S_SETUP: begin
            case (kind_type'(kind_ff))
               KIND_SUB: begin
                  unit_req.op = UNIT_SUB;
                  unit_req.x  = {sign_a, a_ff};
                  unit_req.y  = {sign_b, b_ff};
               end
               KIND_MUL: begin
                  unit_req.op = UNIT_MUL;
                  unit_req.x  = {1'b0, mag_a};
                  unit_req.y  = {1'b0, mag_b};
               end
               default: begin
                  unit_req.op = UNIT_ADD;
                  unit_req.x  = {sign_a, a_ff};
                  unit_req.y  = {sign_b, b_ff};
               end
            endcase
         end
         S_DIV: begin
            unit_req.op = UNIT_SUB;
            unit_req.x  = {rem_ff, acc_ff[DATA_W-1]};
            unit_req.y  = {1'b0, magb_ff};
         end
         S_POW: begin
            unit_req.op = UNIT_MUL;
            unit_req.x  = {1'b0, acc_ff};
            unit_req.y  = {1'b0, magb_ff};
         end
         default: begin
            unit_req.op = UNIT_ADD;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      magb_in       = magb_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      big_in        = big_ff;
      status_in     = status_ff;
      rsp_valid_in  = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in  = req_kind;
               a_in     = req_operand_a;
               b_in     = req_operand_b;
               state_in = S_SETUP;
            end
         end

         S_SETUP: begin
            status_in = ST_OK;
            neg_in    = 1'b0;
            big_in    = 1'b0;
            state_in  = S_FINAL;
            case (kind_type'(kind_ff))
               KIND_ADD, KIND_SUB: begin
                  neg_in = sum_lo[UNIT_W];
                  acc_in = sum_mag[DATA_W-1:0];
                  big_in = |sum_mag[UNIT_W:DATA_W];
               end
               KIND_MUL: begin
                  neg_in = sign_a ^ sign_b;
                  acc_in = unit_res[DATA_W-1:0];
                  big_in = |unit_res[RES_W-1:DATA_W];
               end
               KIND_DIV: begin
                  if (b_ff == '0) begin
                     status_in = ST_DIV_ZERO;
                  end else begin
                     neg_in   = sign_a ^ sign_b;
                     acc_in   = mag_a;
                     magb_in  = mag_b;
                     rem_in   = '0;
                     cnt_in   = '1;
                     state_in = S_DIV;
                  end
               end
               KIND_POW: begin
                  neg_in = sign_a & b_ff[0];
                  if (sign_b) begin
                     status_in = ST_NOT_INTEGRAL;
                  end else if (mag_a[DATA_W-1:1] == '0) begin
                     // base of zero or plus/minus one
                     acc_in = (mag_a[0] == 1'b0 && b_ff != '0) ? '0 : DATA_W'(1);
                  end else if (b_ff > POW_EXP_MAX) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     acc_in   = DATA_W'(1);
                     magb_in  = mag_a;
                     cnt_in   = b_ff[CNT_W-1:0];
                     state_in = S_POW;
                  end
               end
               default: begin
                  status_in = ST_OVERFLOW;
               end
            endcase
         end

         S_DIV: begin
            acc_in = {acc_ff[DATA_W-2:0], fits};
            rem_in = rem_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               status_in = (rem_next != '0) ? ST_NOT_INTEGRAL : ST_OK;
               state_in  = S_FINAL;
            end
         end

         S_POW: begin
            if (cnt_ff == '0) begin
               state_in = S_FINAL;
            end else if (|unit_res[RES_W-1:DATA_W-1]) begin
               // magnitude already at or past 2^31: no way back into range
               status_in = ST_OVERFLOW;
               state_in  = S_FINAL;
            end else begin
               acc_in = unit_res[DATA_W-1:0];
               cnt_in = cnt_ff - 1'b1;
            end
         end

         S_FINAL: begin
            rsp_valid_in = 1'b1;
            if (res_ok) begin
               rsp_value_in  = neg_ff ? (~acc_ff + 1'b1) : acc_ff;
               rsp_status_in = ST_OK;
            end else begin
               rsp_value_in  = '0;
               rsp_status_in = (status_ff == ST_OK) ? ST_OVERFLOW : status_ff;
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      magb_ff       <= magb_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      neg_ff        <= neg_in;
      big_ff        <= big_in;
      status_ff     <= status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

FILE: hdl/cia_check.sv
module cia_check import cia_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [DATA_W-1:0] rsp_value,
   input logic [1:0]        rsp_status
);

   // a result only appears once the sequencer is free again
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // a transfer in starts the sequencer
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // one result per item, never two in a row
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // error results carry a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_value == '0))
      else $error("nonzero value with error status");

   // good results stay strictly inside the signed range
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK) |->
      (rsp_value != 32'h8000_0000 && rsp_value != 32'h7FFF_FFFF))
      else $error("range limit reported as a good result");

endmodule

bind checked_int_alu cia_check u_cia_check (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_valid  (rsp_valid),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);
